### rtl/core/fcbe_pkg.sv
// Shared constants, item kind codes and the character clean-up function
// for the front compression bigram encoder. No dependencies.
`timescale 1ns / 1ps

package fcbe_pkg;

    // Item kind codes on the input channel.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Coded stream constants.
    localparam logic [7:0] ESCAPE_CODE = 8'd30;
    localparam logic [7:0] PAIR_FLAG   = 8'h80;
    localparam int         DIFF_OFFSET = 14;

    // Character constants.
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_QMARK = 7'h3F;
    localparam logic [6:0] CHAR_DEL   = 7'h7F;

    typedef logic [6:0] pchar_t;

    // Masks a raw byte to seven bits and turns control characters into '?'.
    function automatic pchar_t squelch(input logic [7:0] raw);
        pchar_t c;
        c = raw[6:0];
        if (c < CHAR_SPACE || c == CHAR_DEL)
        begin
            c = CHAR_QMARK;
        end
        return c;
    endfunction

endpackage

### rtl/core/front_compress_bigram_encoder.sv
// Front compression plus bigram encoder for a sorted stream of path names.
// Depends on fcbe_pkg for kind codes, stream constants and squelch().
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// input    | in_valid / in_ready   | kind, table_index, data_byte
// output   | out_valid / out_ready | out_byte, last
//
// Every item passes through the accept state and then the look-up state,
// and each output byte then goes through the single output register. A
// character that completes a pair scans the bigram table memory one entry
// per cycle from the start, ending early at the first match or the first
// zero byte. After reset no clearing pass is needed: table entries carry
// valid bits and the previous path memory is guarded by its length.
// in_ready is low while an item is being worked on or its bytes are still
// being handed to the output register.

module front_compress_bigram_encoder #(
    parameter int PATH_CAPACITY = 1024,
    parameter int TABLE_BYTES   = 256
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] table_index,
    input  logic [7:0] data_byte,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);

    // Position counters must be able to hold the capacity itself.
    localparam int PW = $clog2(PATH_CAPACITY + 1);
    localparam int AW = $clog2(PATH_CAPACITY);
    localparam int DW = PW + 1;
    localparam int TW = $clog2(TABLE_BYTES);
    localparam int SW = TW + 1;

    localparam logic [PW-1:0] POS_CAP     = PW'(PATH_CAPACITY);
    localparam logic [SW-1:0] SCAN_END    = SW'(TABLE_BYTES);
    localparam logic [8:0]    TABLE_LIMIT = 9'(TABLE_BYTES);
    localparam logic signed [DW-1:0] DIFF_LO = DW'(-fcbe_pkg::DIFF_OFFSET);
    localparam logic signed [DW-1:0] DIFF_HI = DW'(fcbe_pkg::DIFF_OFFSET);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // Control state.
    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    logic          still_reg, still_next;
    logic          hv_reg, hv_next;
    logic          ent0_reg, ent0_next;
    logic [SW-1:0] sk_reg, sk_next;
    logic          dv_reg, dv_next;
    logic          prev_ok_reg, prev_ok_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [2:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [TABLE_BYTES-1:0] tvalid_reg, tvalid_next;

    // Payload state.
    logic [1:0]    ikind_reg, ikind_next;
    logic [7:0]    iidx_reg, iidx_next;
    logic [7:0]    idata_reg, idata_next;
    fcbe_pkg::pchar_t held_reg, held_next;
    fcbe_pkg::pchar_t pa_reg, pa_next;
    fcbe_pkg::pchar_t pb_reg, pb_next;
    logic [7:0]    prev_byte_reg, prev_byte_next;
    logic [4:0][7:0] buf_reg, buf_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          last_reg, last_next;

    // Memories and their registered read data.
    fcbe_pkg::pchar_t pmem [PATH_CAPACITY];
    logic [7:0]       tmem [TABLE_BYTES];
    fcbe_pkg::pchar_t pd_q;
    logic [7:0]       td_q;
    logic             tv_q;

    // Decoded item and derived values.
    fcbe_pkg::pchar_t      cur_char;
    fcbe_pkg::pchar_t      stored_char;
    logic                  path_match;
    logic                  pos_full;
    logic                  load_ok;
    logic                  pmem_we;
    logic                  tmem_we;
    logic signed [DW-1:0]  diff;
    logic                  diff_small;
    logic [31:0]           diff_word;
    logic [7:0]            tb;
    logic [8:0]            p9;

    assign cur_char    = fcbe_pkg::squelch(idata_reg);
    assign stored_char = (pos_reg == '0 && !ent0_reg) ? fcbe_pkg::CHAR_SPACE : pd_q;
    assign path_match  = (pos_reg < plen_reg) && (stored_char == cur_char);
    assign pos_full    = (pos_reg == POS_CAP);
    assign load_ok     = ({1'b0, iidx_reg} < TABLE_LIMIT);

    // Change of prefix length; the offset word doubles as the short code.
    assign diff       = $signed({1'b0, pos_reg}) - $signed({1'b0, pcnt_reg});
    assign diff_small = (diff >= DIFF_LO) && (diff <= DIFF_HI);
    assign diff_word  = {{(32 - DW){diff[DW-1]}}, diff}
                      + 32'(fcbe_pkg::DIFF_OFFSET);

    // Table bytes never written read as zero.
    assign tb = tv_q ? td_q : 8'd0;
    // The pair candidate sits two entries behind the issue counter.
    assign p9 = 9'(sk_reg) - 9'd2;

    assign pmem_we = (state_reg == ST_LOOK) && (ikind_reg == fcbe_pkg::KIND_CHAR)
                   && !pos_full;
    assign tmem_we = (state_reg == ST_LOOK) && (ikind_reg == fcbe_pkg::KIND_LOAD)
                   && load_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        plen_next      = plen_reg;
        pcnt_next      = pcnt_reg;
        still_next     = still_reg;
        hv_next        = hv_reg;
        ent0_next      = ent0_reg;
        sk_next        = sk_reg;
        dv_next        = dv_reg;
        prev_ok_next   = prev_ok_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        tvalid_next    = tvalid_reg;
        ikind_next     = ikind_reg;
        iidx_next      = iidx_reg;
        idata_next     = idata_reg;
        held_next      = held_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        prev_byte_next = prev_byte_reg;
        buf_next       = buf_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        // The output register empties when its byte is taken.
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ikind_next = kind;
                    iidx_next  = table_index;
                    idata_next = data_byte;
                    state_next = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                idx_next   = 3'd0;
                state_next = ST_IDLE;
                case (ikind_reg)
                    fcbe_pkg::KIND_LOAD:
                    begin
                        if (load_ok)
                        begin
                            tvalid_next[iidx_reg[TW-1:0]] = 1'b1;
                            buf_next[0] = idata_reg;
                            cnt_next    = 3'd1;
                            state_next  = ST_EMIT;
                        end
                    end

                    fcbe_pkg::KIND_CHAR:
                    begin
                        if (!pos_full)
                        begin
                            pos_next = pos_reg + PW'(1);
                            if (pos_reg == '0)
                            begin
                                ent0_next = 1'b1;
                            end
                            if (still_reg)
                            begin
                                if (!path_match)
                                begin
                                    if (diff_small)
                                    begin
                                        buf_next[0] = diff_word[7:0];
                                        cnt_next    = 3'd1;
                                    end
                                    else
                                    begin
                                        buf_next = {diff_word[31:24], diff_word[23:16],
                                                    diff_word[15:8], diff_word[7:0],
                                                    fcbe_pkg::ESCAPE_CODE};
                                        cnt_next = 3'd5;
                                    end
                                    pcnt_next  = pos_reg;
                                    still_next = 1'b0;
                                    held_next  = cur_char;
                                    hv_next    = 1'b1;
                                    state_next = ST_EMIT;
                                end
                            end
                            else if (hv_reg)
                            begin
                                hv_next      = 1'b0;
                                pa_next      = held_reg;
                                pb_next      = cur_char;
                                sk_next      = '0;
                                dv_next      = 1'b0;
                                prev_ok_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                            else
                            begin
                                held_next = cur_char;
                                hv_next   = 1'b1;
                            end
                        end
                    end

                    fcbe_pkg::KIND_END:
                    begin
                        if (still_reg)
                        begin
                            if (diff_small)
                            begin
                                buf_next[0] = diff_word[7:0];
                                cnt_next    = 3'd1;
                            end
                            else
                            begin
                                buf_next = {diff_word[31:24], diff_word[23:16],
                                            diff_word[15:8], diff_word[7:0],
                                            fcbe_pkg::ESCAPE_CODE};
                                cnt_next = 3'd5;
                            end
                            pcnt_next  = pos_reg;
                            state_next = ST_EMIT;
                        end
                        else if (hv_reg)
                        begin
                            buf_next[0] = {1'b0, held_reg};
                            cnt_next    = 3'd1;
                            state_next  = ST_EMIT;
                        end
                        plen_next  = pos_reg;
                        pos_next   = '0;
                        still_next = 1'b1;
                        hv_next    = 1'b0;
                        held_next  = '0;
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SCAN:
            begin
                // Issue one table read per cycle until every entry is out.
                if (sk_reg != SCAN_END)
                begin
                    sk_next = sk_reg + SW'(1);
                    dv_next = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end

                if (dv_reg)
                begin
                    if (tb == 8'd0)
                    begin
                        buf_next  = {24'd0, {1'b0, pb_reg}, {1'b0, pa_reg}};
                        cnt_next  = 3'd2;
                        state_next = ST_EMIT;
                    end
                    else if (prev_ok_reg && prev_byte_reg == {1'b0, pa_reg}
                             && tb == {1'b0, pb_reg})
                    begin
                        if (!p9[0])
                        begin
                            buf_next[0] = fcbe_pkg::PAIR_FLAG | {1'b0, p9[7:1]};
                            cnt_next    = 3'd1;
                        end
                        else
                        begin
                            buf_next = {24'd0, {1'b0, pb_reg}, {1'b0, pa_reg}};
                            cnt_next = 3'd2;
                        end
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        prev_byte_next = tb;
                        prev_ok_next   = 1'b1;
                    end
                end
                else if (sk_reg == SCAN_END)
                begin
                    // Whole table read without a match.
                    buf_next   = {24'd0, {1'b0, pb_reg}, {1'b0, pa_reg}};
                    cnt_next   = 3'd2;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_byte_next  = buf_reg[idx_reg];
                    last_next      = (idx_reg == cnt_reg - 3'd1);
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 3'd1;
                    if (idx_reg == cnt_reg - 3'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            plen_reg      <= PW'(1);
            pcnt_reg      <= '0;
            still_reg     <= 1'b1;
            hv_reg        <= 1'b0;
            ent0_reg      <= 1'b0;
            sk_reg        <= '0;
            dv_reg        <= 1'b0;
            prev_ok_reg   <= 1'b0;
            cnt_reg       <= 3'd0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            tvalid_reg    <= '0;
            held_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            plen_reg      <= plen_next;
            pcnt_reg      <= pcnt_next;
            still_reg     <= still_next;
            hv_reg        <= hv_next;
            ent0_reg      <= ent0_next;
            sk_reg        <= sk_next;
            dv_reg        <= dv_next;
            prev_ok_reg   <= prev_ok_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            tvalid_reg    <= tvalid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ikind_reg     <= ikind_next;
        iidx_reg      <= iidx_next;
        idata_reg     <= idata_next;
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        prev_byte_reg <= prev_byte_next;
        buf_reg       <= buf_next;
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
    end

    // Previous path memory: read at the current position, written once the
    // comparison has been made.
    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            pmem[pos_reg[AW-1:0]] <= cur_char;
        end
        pd_q <= pmem[pos_reg[AW-1:0]];
    end

    // Bigram table memory: written by load items, read by the pair scan.
    always_ff @(posedge clk)
    begin
        if (tmem_we)
        begin
            tmem[iidx_reg[TW-1:0]] <= idata_reg;
        end
        td_q <= tmem[sk_reg[TW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_q <= 1'b0;
        end
        else
        begin
            tv_q <= tvalid_reg[sk_reg[TW-1:0]];
        end
    end

endmodule
